FILE: rtl/core/rrqq_pkg.sv
// shared types and field widths for the round-robin quantum queue
`default_nettype none
package rrqq_pkg;

  localparam int TIME_W = 48;
  localparam int WORK_W = 24;
  localparam int TAG_W  = 32;
  localparam int GAP_W  = 32;

  // one queued job
  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [WORK_W-1:0] remaining;
    logic [TAG_W-1:0]  tag;
  } entry_t;

endpackage
`default_nettype wire

FILE: rtl/core/rrqq_mem.sv
// job store: one write port, one read port with registered read data
`default_nettype none
module rrqq_mem #(
  parameter int DEPTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [$clog2(DEPTH)-1:0]     waddr,
  input  wire rrqq_pkg::entry_t             wdata,
  input  wire logic                         re,
  input  wire logic [$clog2(DEPTH)-1:0]     raddr,
  output rrqq_pkg::entry_t                  rdata
);
  import rrqq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/rrqq_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module rrqq_div #(
  parameter int DW = 30
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [31:0]   dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [31:0]        quot,
  output logic [DW-1:0]      rem
);
  import rrqq_pkg::*;

  localparam int STEPS  = 32;
  localparam int STEP_W = $clog2(STEPS + 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DW-1:0]     acc;
  logic [31:0]       dvd;
  logic [DW-1:0]     dsr;
  logic [DW:0]       sh;
  logic [DW:0]       diff;
  logic              fits;

  always_comb begin
    sh   = {acc, dvd[31]};
    fits = sh >= {1'b0, dsr};
    diff = sh - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        acc  <= '0;
        dvd  <= dividend;
        dsr  <= divisor;
        quot <= '0;
      end else if (busy) begin
        acc  <= fits ? diff[DW-1:0] : sh[DW-1:0];
        dvd  <= {dvd[30:0], 1'b0};
        quot <= {quot[30:0], fits};
        step <= step + STEP_W'(1);
        if (step == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem = acc;

endmodule
`default_nettype wire

FILE: rtl/core/round_robin_quantum_queue.sv
// round-robin time-slice job queue: top level with the slice sequencer
// an item is taken in IDLE, then CHECK; each head slice ended in the gap passes HEAD then GIVE
// (HEAD alone if it empties the queue); ARRIVE then registers its result; a new item is taken only
// once the last result is loaded; a round skip scans the store, multiplies, divides serially and
// writes back if a round fits; a waiting result stalls the sequencer; synchronous reset clears
// clock, head, count, slice and job number, sets quantum to 1024; the job store is not cleared
`default_nettype none
module round_robin_quantum_queue #(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // configuration: quantum
  input  wire logic         cfg_we,
  input  wire logic [23:0]  cfg_wdata,
  // arrivals
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [55:0]  s_tdata,   // gap[31:0], work[55:32]
  // results
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [111:0]      m_tdata,   // job_number[31:0], arrival_time[79:32],
                                       // response_time[111:80]
  output logic [1:0]        m_tuser,   // kind[1:0]
  output logic              m_tlast    // last
);
  import rrqq_pkg::*;

  localparam int IW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW  = CW + 1;
  localparam int NQW = WORK_W + CW;

  localparam logic [1:0] KIND_DONE   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_DROP   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_HEAD,
    ST_GIVE,
    ST_ARRIVE,
    ST_SCAN,
    ST_MUL,
    ST_DIVGO,
    ST_DIVWAIT,
    ST_APPLY
  } state_t;

  // circular index: base plus offset, offset never above the depth
  function automatic logic [IW-1:0] idx_add(input logic [IW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  state_t            state;
  logic [23:0]       quantum;
  logic [TIME_W-1:0] tick_count;
  logic [GAP_W-1:0]  gap_left;
  logic [WORK_W-1:0] work;
  logic [IW-1:0]     head;
  logic [CW-1:0]     count;
  logic [WORK_W-1:0] slice_left;
  logic [TAG_W-1:0]  next_number;
  logic [CW-1:0]     skip_hold;    // slices to play before another skip attempt
  logic [NQW-1:0]    nq;           // one full round in ticks
  logic [WORK_W-1:0] min_left;
  logic [NQW-1:0]    mn;
  logic [31:0]       div_dvd;
  logic [WORK_W-1:0] kq;           // ticks taken from every job by a skip
  logic [CW-1:0]     scan_issue;
  logic              scan_pend;
  logic              scan_first;
  logic [IW-1:0]     scan_addr;
  logic              fwd_valid;
  entry_t            fwd_entry;

  logic [1:0]        out_kind;
  logic [31:0]       out_num;
  logic [TIME_W-1:0] out_arr;
  logic [31:0]       out_resp;

  // store ports
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  logic              mem_re;
  logic [IW-1:0]     mem_raddr;
  entry_t            mem_rdata;

  // divider ports
  logic              div_start;
  logic [31:0]       div_dividend;
  logic              div_done;
  logic [31:0]       div_quot;
  logic [NQW-1:0]    div_rem;

  // combinational decisions
  logic [WORK_W-1:0] eff_q;
  logic              out_free;
  logic              out_load;
  logic              skip_ok;
  logic              check_slice;
  logic              rotate;
  logic              head_go;
  logic [IW-1:0]     tail;
  logic [IW-1:0]     new_head;
  logic [CW-1:0]     count_dec;
  entry_t            give_e;
  logic [WORK_W-1:0] give_slice;
  logic [TIME_W-1:0] resp_full;
  logic [31:0]       resp_sat;
  logic [TIME_W-1:0] arrive_time;
  logic              full;
  logic [WORK_W-1:0] new_slice;
  logic              scan_more;
  logic [WORK_W-1:0] scan_t;

  rrqq_mem #(
    .DEPTH (QUEUE_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rrqq_div #(
    .DW (NQW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (nq),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    // a zero quantum behaves as one tick
    eff_q       = (quantum == '0) ? WORK_W'(1) : quantum;
    out_free    = !m_tvalid || m_tready;
    // skip only pays off when the gap covers at least two full rounds
    skip_ok     = (count != '0) && (slice_left == eff_q) && (skip_hold == '0) &&
                  (64'(gap_left) >= (64'(nq) << 1));
    check_slice = (count != '0) && (gap_left >= GAP_W'(slice_left));
    rotate      = mem_rdata.remaining != '0;
    head_go     = rotate || out_free;
    // a new result goes into the output register this cycle
    out_load    = ((state == ST_HEAD) && head_go && !rotate) ||
                  ((state == ST_ARRIVE) && out_free);
    tail        = idx_add(head, count);
    new_head    = idx_add(head, CW'(1));
    count_dec   = rotate ? count : count - CW'(1);
    give_e      = fwd_valid ? fwd_entry : mem_rdata;
    give_slice  = (give_e.remaining < eff_q) ? give_e.remaining : eff_q;
    resp_full   = tick_count - mem_rdata.arrival;
    resp_sat    = (resp_full[TIME_W-1:32] != '0) ? '1 : resp_full[31:0];
    arrive_time = tick_count + TIME_W'(gap_left);
    full        = count == CW'(QUEUE_DEPTH);
    new_slice   = (work < eff_q) ? work : eff_q;
    scan_more   = scan_issue != count;
    // head may use its whole remainder, others must keep at least one tick
    if (scan_first) begin
      scan_t = mem_rdata.remaining;
    end else if (mem_rdata.remaining == '0) begin
      scan_t = '0;
    end else begin
      scan_t = mem_rdata.remaining - WORK_W'(1);
    end
    div_start    = state == ST_DIVGO;
    div_dividend = (64'(mn) < 64'(gap_left)) ? 32'(mn) : gap_left;
  end

  // store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = head;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = head;
    unique case (state)
      ST_CHECK: begin
        if (!skip_ok && check_slice) begin
          mem_re = 1'b1;
        end
      end
      ST_HEAD: begin
        if (head_go) begin
          if (rotate) begin
            mem_we    = 1'b1;
            mem_waddr = tail;
          end
          if (count_dec != '0) begin
            mem_re    = 1'b1;
            mem_raddr = new_head;
          end
        end
      end
      ST_GIVE: begin
        mem_we              = 1'b1;
        mem_wdata           = give_e;
        mem_wdata.remaining = give_e.remaining - give_slice;
      end
      ST_ARRIVE: begin
        if (out_free && !full) begin
          mem_we              = 1'b1;
          mem_waddr           = tail;
          mem_wdata.arrival   = arrive_time;
          mem_wdata.remaining = (count == '0) ? work - new_slice : work;
          mem_wdata.tag       = next_number;
        end
      end
      ST_SCAN: begin
        if (scan_more) begin
          mem_re    = 1'b1;
          mem_raddr = idx_add(head, scan_issue);
        end
      end
      ST_APPLY: begin
        if (scan_more) begin
          mem_re    = 1'b1;
          mem_raddr = idx_add(head, scan_issue);
        end
        if (scan_pend) begin
          mem_we              = 1'b1;
          mem_waddr           = scan_addr;
          mem_wdata.remaining = mem_rdata.remaining - kq;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      quantum     <= 24'd1024;
      tick_count  <= '0;
      head        <= '0;
      count       <= '0;
      slice_left  <= '0;
      next_number <= '0;
      skip_hold   <= '0;
      fwd_valid   <= 1'b0;
      scan_pend   <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        quantum <= cfg_wdata;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      // round length follows the job count and quantum through a register
      nq <= NQW'(count) * NQW'(eff_q);

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            gap_left  <= s_tdata[31:0];
            work      <= s_tdata[55:32];
            skip_hold <= '0;
            state     <= ST_CHECK;
          end
        end

        ST_CHECK: begin
          if (skip_ok) begin
            scan_issue <= '0;
            scan_pend  <= 1'b0;
            scan_first <= 1'b1;
            state      <= ST_SCAN;
          end else if (check_slice) begin
            // head slice ends inside the gap
            tick_count <= tick_count + TIME_W'(slice_left);
            gap_left   <= gap_left - GAP_W'(slice_left);
            state      <= ST_HEAD;
          end else begin
            state <= ST_ARRIVE;
          end
        end

        ST_HEAD: begin
          if (head_go) begin
            if (!rotate) begin
              out_kind <= KIND_DONE;
              out_num  <= mem_rdata.tag;
              out_arr  <= mem_rdata.arrival;
              out_resp <= resp_sat;
              m_tlast  <= 1'b0;
            end
            head  <= new_head;
            count <= count_dec;
            if (skip_hold != '0) begin
              skip_hold <= skip_hold - CW'(1);
            end
            // a lone job rotating onto itself is forwarded past the store
            fwd_valid <= rotate && (tail == new_head);
            fwd_entry <= mem_rdata;
            if (count_dec != '0) begin
              state <= ST_GIVE;
            end else begin
              slice_left <= '0;
              state      <= ST_CHECK;
            end
          end
        end

        ST_GIVE: begin
          slice_left <= give_slice;
          fwd_valid  <= 1'b0;
          state      <= ST_CHECK;
        end

        ST_ARRIVE: begin
          if (out_free) begin
            tick_count  <= arrive_time;
            next_number <= next_number + TAG_W'(1);
            out_num     <= next_number;
            out_arr     <= arrive_time;
            out_resp    <= '0;
            m_tlast     <= 1'b1;
            if (count != '0) begin
              slice_left <= slice_left - gap_left[WORK_W-1:0];
            end
            if (full) begin
              out_kind <= KIND_DROP;
            end else begin
              out_kind <= KIND_ACCEPT;
              count    <= count + CW'(1);
              if (count == '0) begin
                slice_left <= new_slice;
              end
            end
            state <= ST_IDLE;
          end
        end

        // least headroom over all queued jobs
        ST_SCAN: begin
          if (scan_more) begin
            scan_issue <= scan_issue + CW'(1);
          end
          scan_pend <= scan_more;
          if (scan_pend) begin
            scan_first <= 1'b0;
            if (scan_first || (scan_t < min_left)) begin
              min_left <= scan_t;
            end
          end
          if (!scan_more && !scan_pend) begin
            state <= ST_MUL;
          end
        end

        ST_MUL: begin
          mn    <= NQW'(min_left) * NQW'(count);
          state <= ST_DIVGO;
        end

        // rounds = min(headroom x jobs, gap) / round length
        ST_DIVGO: begin
          div_dvd <= div_dividend;
          state   <= ST_DIVWAIT;
        end

        ST_DIVWAIT: begin
          if (div_done) begin
            if (div_quot == '0) begin
              skip_hold <= count;
              state     <= ST_CHECK;
            end else begin
              tick_count <= tick_count + TIME_W'(div_dvd - 32'(div_rem));
              gap_left   <= gap_left - (div_dvd - 32'(div_rem));
              kq         <= WORK_W'(div_quot[WORK_W-1:0] * eff_q);
              scan_issue <= '0;
              scan_pend  <= 1'b0;
              state      <= ST_APPLY;
            end
          end
        end

        // take the skipped ticks from every job, read then write back
        ST_APPLY: begin
          if (scan_more) begin
            scan_issue <= scan_issue + CW'(1);
            scan_addr  <= idx_add(head, scan_issue);
          end
          scan_pend <= scan_more;
          if (!scan_more && !scan_pend) begin
            skip_hold <= count;
            state     <= ST_CHECK;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_tready = state == ST_IDLE;
  assign m_tdata  = {out_resp, out_arr, out_num};
  assign m_tuser  = out_kind;

endmodule
`default_nettype wire
